### src/prrs_pkg.sv
package prrs_pkg;

  localparam int NEED_W = 8;
  localparam int PID_W  = 4;

  // input word kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // scheduling modes
  localparam logic MODE_PRIO = 1'b0;
  localparam logic MODE_RR   = 1'b1;

  // configuration register indexes
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [NEED_W-1:0] QUANTUM_RESET = 8'd2;
  localparam logic [NEED_W-1:0] SAT_MAX       = 8'hFF;

  // classified word handed from the front to the back
  typedef struct packed {
    logic              tick;
    logic              rr;
    logic [NEED_W-1:0] need;
  } cmd_t;

  typedef struct packed {
    logic              idle;
    logic [PID_W-1:0]  proc_id;
    logic [NEED_W-1:0] used_time;
    logic [NEED_W-1:0] left_time;
    logic              finished;
    logic              rotated;
  } res_t;

endpackage

### src/prrs_fifo.sv
module prrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CW-1:0]    cnt;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign wr_ok   = wr_en & ~full;
  assign rd_ok   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + CW'(wr_ok) - CW'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### src/prrs_front.sv
module prrs_front #(
  parameter int MAX_PROCS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               func,
  input  logic [prrs_pkg::NEED_W-1:0]        need_time,
  input  logic                               mode,
  input  logic                               cmd_full,
  output logic                               cmd_push,
  output prrs_pkg::cmd_t                     cmd
);

  import prrs_pkg::*;

  localparam int CNTW = $clog2(MAX_PROCS + 1);

  logic [CNTW-1:0] loaded;
  logic            accept;
  logic            is_tick;
  logic            load_ok;

  assign full    = cmd_full;
  assign accept  = push & ~cmd_full;
  assign is_tick = (func == FUNC_TICK);
  // drop loads with no need and loads beyond capacity here
  assign load_ok = (need_time != '0) && (loaded < CNTW'(MAX_PROCS));

  assign cmd_push  = accept & (is_tick | load_ok);
  assign cmd.tick  = is_tick;
  assign cmd.rr    = (mode == MODE_RR);
  assign cmd.need  = need_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (accept && !is_tick && load_ok) begin
      loaded <= loaded + 1'b1;
    end
  end

endmodule

### src/prrs_back.sv
module prrs_back #(
  parameter int MAX_PROCS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mode,
  input  logic [prrs_pkg::NEED_W-1:0] quantum,
  input  logic                        cmd_valid,
  input  prrs_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output prrs_pkg::res_t              res
);

  import prrs_pkg::*;

  localparam int IDW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNTW = $clog2(MAX_PROCS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  typedef struct packed {
    logic [IDW-1:0]    id;
    logic [NEED_W-1:0] rem;
    logic [NEED_W-1:0] used;
  } entry_t;

  entry_t            q      [MAX_PROCS];
  entry_t            q_next [MAX_PROCS];
  logic [CNTW-1:0]   count, count_next;
  logic              state, state_next;
  logic [CNTW-1:0]   pos, pos_next;
  logic [IDW-1:0]    ld_id, ld_id_next;
  entry_t            run, run_next;
  logic              run_valid, run_valid_next;
  logic [NEED_W-1:0] slice, slice_next;

  logic [MAX_PROCS-1:0] le;
  logic              q_pop;
  logic              q_ins;
  logic [CNTW-1:0]   ins_pos;
  entry_t            ins_entry;

  logic              disp;
  entry_t            cur;
  entry_t            charged;
  logic [CNTW-1:0]   cnt_after;
  logic [NEED_W-1:0] slice_base;
  logic [NEED_W-1:0] slice_new;
  logic              fin;
  logic              rot_due;
  logic              rot;

  // per-entry compare against the incoming need
  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_le
    assign le[k] = (q[k].rem <= cmd.need);
  end

  // charge one tick to the head (when dispatched) or the running process
  always_comb begin
    disp       = !run_valid && (count != '0);
    cur        = disp ? q[0] : run;
    cnt_after  = count - CNTW'(disp);
    charged    = cur;
    charged.rem  = (cur.rem != '0) ? cur.rem - 1'b1 : cur.rem;
    charged.used = (cur.used == SAT_MAX) ? cur.used : cur.used + 1'b1;
    slice_base = disp ? '0 : slice;
    slice_new  = (slice_base == SAT_MAX) ? slice_base : slice_base + 1'b1;
    fin        = (charged.rem == '0);
    rot_due    = !fin && (mode == MODE_RR) && (slice_new >= quantum);
    rot        = rot_due && (cnt_after != '0);
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    ld_id_next     = ld_id;
    run_next       = run;
    run_valid_next = run_valid;
    slice_next     = slice;
    q_pop          = 1'b0;
    q_ins          = 1'b0;
    ins_pos        = count;
    ins_entry      = charged;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.tick) begin
            if (!res_full) begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
              if (!run_valid && count == '0) begin
                res.idle = 1'b1;
              end else begin
                q_pop          = disp;
                run_next       = charged;
                run_valid_next = !(fin || rot);
                slice_next     = (fin || rot_due) ? '0 : slice_new;
                if (rot) begin
                  q_ins   = 1'b1;
                  ins_pos = cnt_after;
                end
                res.proc_id   = PID_W'(cur.id);
                res.used_time = charged.used;
                res.left_time = charged.rem;
                res.finished  = fin;
                res.rotated   = rot;
              end
            end
          end else if (cmd.rr) begin
            // round robin: append at the tail
            q_ins          = 1'b1;
            ins_pos        = count;
            ins_entry.id   = ld_id;
            ins_entry.rem  = cmd.need;
            ins_entry.used = '0;
            ld_id_next     = ld_id + 1'b1;
            cmd_pop        = 1'b1;
          end else begin
            pos_next   = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // advance past every entry with the same or smaller need
        if (pos < count && le[pos[IDW-1:0]]) begin
          pos_next = pos + 1'b1;
        end else begin
          q_ins          = 1'b1;
          ins_pos        = pos;
          ins_entry.id   = ld_id;
          ins_entry.rem  = cmd.need;
          ins_entry.used = '0;
          ld_id_next     = ld_id + 1'b1;
          cmd_pop        = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    count_next = count - CNTW'(q_pop) + CNTW'(q_ins);
  end

  // queue slots: each takes the new word, its left or right neighbour, or holds
  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_q
    localparam int KP = (k > 0) ? k - 1 : 0;
    localparam int KN = (k + 1 < MAX_PROCS) ? k + 1 : k;
    always_comb begin
      priority if (q_ins && ins_pos == CNTW'(k)) begin
        q_next[k] = ins_entry;
      end else if (q_ins && ins_pos < CNTW'(k)) begin
        q_next[k] = q[KP];
      end else if (q_pop) begin
        q_next[k] = q[KN];
      end else begin
        q_next[k] = q[k];
      end
    end
    always_ff @(posedge clk) begin
      q[k] <= q_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      ld_id     <= '0;
      run_valid <= 1'b0;
      run.id    <= '0;
      slice     <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pos       <= pos_next;
      ld_id     <= ld_id_next;
      run_valid <= run_valid_next;
      run       <= run_next;
      slice     <= slice_next;
    end
  end

endmodule

### src/priority_and_round_robin_scheduler_top.sv
// Process scheduler, shortest-need priority or round robin.
// Input channel (push/full): func selects a load (need_time ticks) or one
// scheduling tick. Loads give no result word; each tick gives exactly one.
// Result channel (empty/pop): idle, proc_id, used_time, left_time, finished
// and rotated of the oldest waiting word are on the ports while empty is low.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 mode,
// 1 quantum) at the clock edge; write only while the block is quiet.
// Words pass a four-entry command queue to the execution unit and a two-entry
// result queue. A tick is written into the command queue, handled by the
// execution unit and written into the result queue, whose head drives the
// ports; ticks can follow one per cycle while the result queue has room and
// no priority load is scanning. A round-robin load is appended at the tail
// directly; a priority load walks past p queued processes, p being at most
// MAX_PROCS - 1 (one queue entry compared per cycle), before it is inserted.
// Reset (rst, synchronous) empties both queues and the ready queue, clears
// the running process and slot counter, and sets mode 0 and quantum 2.
// When the receiver holds off pop, results collect in the result queue and
// then the command queue; full rises once the command queue is full.
module priority_and_round_robin_scheduler_top #(
  parameter int MAX_PROCS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        func,
  input  logic [prrs_pkg::NEED_W-1:0] need_time,
  output logic                        empty,
  input  logic                        pop,
  output logic                        idle,
  output logic [prrs_pkg::PID_W-1:0]  proc_id,
  output logic [prrs_pkg::NEED_W-1:0] used_time,
  output logic [prrs_pkg::NEED_W-1:0] left_time,
  output logic                        finished,
  output logic                        rotated,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [prrs_pkg::NEED_W-1:0] cfg_data
);

  import prrs_pkg::*;

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;
  localparam int CMD_W     = $bits(cmd_t);
  localparam int RES_W     = $bits(res_t);

  logic              mode;
  logic [NEED_W-1:0] quantum;

  logic              cmd_push;
  logic              cmd_full;
  cmd_t              cmd_in;
  logic [CMD_W-1:0]  cmd_rd;
  cmd_t              cmd_out;
  logic              cmd_empty;
  logic              cmd_pop;

  logic              res_push;
  logic              res_full;
  res_t              res_in;
  logic [RES_W-1:0]  res_rd;
  res_t              res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PRIO;
      quantum <= QUANTUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:    mode    <= cfg_data[0];
        CFG_QUANTUM: quantum <= cfg_data;
      endcase
    end
  end

  prrs_front #(.MAX_PROCS(MAX_PROCS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .need_time (need_time),
    .mode      (mode),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  prrs_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  assign cmd_out = cmd_rd;

  prrs_back #(.MAX_PROCS(MAX_PROCS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .quantum   (quantum),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  prrs_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign res_out   = res_rd;
  assign idle      = res_out.idle;
  assign proc_id   = res_out.proc_id;
  assign used_time = res_out.used_time;
  assign left_time = res_out.left_time;
  assign finished  = res_out.finished;
  assign rotated   = res_out.rotated;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import prrs_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int QUIET_WAIT = 120;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              func = FUNC_TICK;
  logic [NEED_W-1:0] need_time = '0;
  logic              pop = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = CFG_MODE;
  logic [NEED_W-1:0] cfg_data = '0;
  logic              full, empty, idle, finished, rotated;
  logic [PID_W-1:0]  proc_id;
  logic [NEED_W-1:0] used_time, left_time;

  // scheduler state as predicted
  int                sched_q[$];
  logic [NEED_W-1:0] need_left [SLOTS];
  logic [NEED_W-1:0] ticks_got [SLOTS];
  bit                busy;
  int                cur_slot;
  int                slice;
  int                slots_used;
  logic              sched_mode = MODE_PRIO;
  logic [NEED_W-1:0] slice_limit = QUANTUM_RESET;

  res_t tick_results[$];
  res_t want;
  int   gap_pct = 30;
  int   errors = 0;
  int   cycles = 0;

  priority_and_round_robin_scheduler_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .need_time(need_time),
    .empty(empty), .pop(pop), .idle(idle), .proc_id(proc_id), .used_time(used_time),
    .left_time(left_time), .finished(finished), .rotated(rotated),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("priority_and_round_robin_scheduler_top verification failed");
      $finish;
    end
  end

  function automatic void predict_word(logic f, logic [NEED_W-1:0] nt);
    res_t r;
    int   pos;
    if (f == FUNC_LOAD) begin
      if (nt != 0 && slots_used < SLOTS) begin
        need_left[slots_used] = nt;
        ticks_got[slots_used] = '0;
        pos = sched_q.size();
        if (sched_mode == MODE_PRIO) begin
          // stable: go behind every entry with equal or smaller need
          pos = 0;
          while (pos < sched_q.size() && need_left[sched_q[pos]] <= nt) pos++;
        end
        sched_q.insert(pos, slots_used);
        slots_used++;
      end
      return;
    end
    r = '0;
    if (!busy && sched_q.size() > 0) begin
      cur_slot = sched_q.pop_front();
      busy = 1'b1;
      slice = 0;
    end
    if (!busy) begin
      r.idle = 1'b1;
    end else begin
      if (ticks_got[cur_slot] < SAT_MAX) ticks_got[cur_slot]++;
      if (need_left[cur_slot] > 0) need_left[cur_slot]--;
      if (slice < 255) slice++;
      if (need_left[cur_slot] == 0) begin
        r.finished = 1'b1;
        busy = 1'b0;
        slice = 0;
      end else if (sched_mode == MODE_RR && slice >= slice_limit) begin
        slice = 0;
        if (sched_q.size() > 0) begin
          sched_q.push_back(cur_slot);
          busy = 1'b0;
          r.rotated = 1'b1;
        end
      end
      r.proc_id   = cur_slot[PID_W-1:0];
      r.used_time = ticks_got[cur_slot];
      r.left_time = need_left[cur_slot];
    end
    tick_results.push_back(r);
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(0, 99) >= gap_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (tick_results.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
      end else begin
        want = tick_results.pop_front();
        check_field("idle", want.idle, idle);
        check_field("proc_id", want.proc_id, proc_id);
        check_field("used_time", want.used_time, used_time);
        check_field("left_time", want.left_time, left_time);
        check_field("finished", want.finished, finished);
        check_field("rotated", want.rotated, rotated);
      end
    end
  end

  // entered and left at a falling edge; push stays high between back-to-back words
  task automatic send_word(input logic f, input logic [NEED_W-1:0] nt);
    if ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
    end
    func <= f;
    need_time <= nt;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_word(f, nt);
    @(negedge clk);
  endtask

  // drain every result, then give queued loads time to clear the back end
  task automatic settle();
    push <= 1'b0;
    while (tick_results.size() != 0) @(negedge clk);
    repeat (QUIET_WAIT) @(negedge clk);
  endtask

  task automatic set_config(input logic m, input logic [NEED_W-1:0] q);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_MODE;
    cfg_data <= {{(NEED_W-1){1'b0}}, m};
    @(posedge clk);
    sched_mode = m;
    @(negedge clk);
    cfg_addr <= CFG_QUANTUM;
    cfg_data <= q;
    @(posedge clk);
    slice_limit = q;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_word(FUNC_TICK, NEED_W'($urandom));
  endtask

  // idle tick, ignored zero need, stable sort on equal needs, then a long one
  task automatic test_priority_order();
    send_word(FUNC_TICK, 8'h00);
    send_word(FUNC_LOAD, 8'd0);
    send_word(FUNC_LOAD, 8'd2);
    send_word(FUNC_LOAD, 8'd1);
    send_word(FUNC_LOAD, 8'd2);
    send_word(FUNC_LOAD, 8'd1);
    send_word(FUNC_LOAD, 8'd255);
    run_ticks(10);
  endtask

  // slice count built up in priority mode carries into round robin
  task automatic test_slice_carry();
    set_config(MODE_RR, 8'd3);
    run_ticks(1);
    send_word(FUNC_LOAD, 8'd1);
    send_word(FUNC_LOAD, 8'd128);
    run_ticks(5);
  endtask

  task automatic test_zero_quantum();
    set_config(MODE_RR, 8'd0);
    run_ticks(4);
  endtask

  task automatic run_phase(input logic m, input logic [NEED_W-1:0] q, input int n_words,
                           input int n_loads, input int pct);
    logic [NEED_W-1:0] nt;
    set_config(m, q);
    gap_pct = pct;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(1, n_words) <= n_loads) begin
        // favour short needs so processes retire within the phase
        nt = $urandom_range(0, 1) ? NEED_W'($urandom_range(1, 255))
                                  : NEED_W'($urandom_range(1, 16));
        send_word(FUNC_LOAD, nt);
      end else begin
        send_word(FUNC_TICK, NEED_W'($urandom));
      end
    end
  endtask

  task automatic test_random_mix();
    run_phase(MODE_RR, 8'd255, 300, 2, 30);
    run_phase(MODE_PRIO, QUANTUM_RESET, 400, 3, 0);
    run_phase(MODE_RR, NEED_W'($urandom_range(1, 8)), 400, 2, 30);
    run_phase(MODE_PRIO, NEED_W'($urandom_range(1, 255)), 400, 1, 30);
    run_phase(MODE_RR, 8'd1, 500, 6, 30);
  endtask

  initial begin
    busy = 1'b0;
    cur_slot = 0;
    slice = 0;
    slots_used = 0;
    for (int i = 0; i < SLOTS; i++) begin
      need_left[i] = '0;
      ticks_got[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_priority_order();
    test_slice_carry();
    test_zero_quantum();
    test_random_mix();
    settle();
    if (errors == 0) begin
      $display("priority_and_round_robin_scheduler_top verification clean");
    end else begin
      $display("priority_and_round_robin_scheduler_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/prrs_pkg.sv
src/prrs_fifo.sv
src/prrs_front.sv
src/prrs_back.sv
src/priority_and_round_robin_scheduler_top.sv
sim/tb.sv
